@@ hdl/tcw_pkg.sv @@
// tcw_pkg: shared types, command codes and constants for the text console writer.
// No dependencies; the core refers to it by scoped names and the bench imports it.
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_ROWS = 25;
  localparam int DEF_COLS = 80;

  // Command codes
  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_DRAW  = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_VISIBLE = 2'd1;

  // Character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  localparam logic [7:0]  RESET_COLOR = 8'h0F;
  localparam logic [15:0] RESET_CELL  = {RESET_COLOR, SPACE_CHAR};
  localparam int CELL_W = 16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] draw_color;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  read_char;
    logic [4:0]  pos_row;
    logic [6:0]  pos_col;
    logic [10:0] cursor_pos;
  } result_t;

endpackage

@@ hdl/tcw_ram.sv @@
// tcw_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tcw_addr_unit.sv @@
// tcw_addr_unit: shared cell address unit, computes a*COLS + b.
// Serves cursor, target, sweep and hardware cursor addresses; no dependencies.
module tcw_addr_unit #(
  parameter int COLS   = 80,
  parameter int ROW_W  = 5,
  parameter int ADDR_W = 11
) (
  input  logic [ROW_W-1:0]  a,
  input  logic [ADDR_W-1:0] b,
  output logic [ADDR_W-1:0] sum
);

  localparam int SW = ADDR_W + ROW_W + 1;

  logic [SW-1:0] prod;
  logic [SW-1:0] total;

  always_comb begin
    prod  = SW'(a) * SW'(COLS);
    total = prod + SW'(b);
    sum   = total[ADDR_W-1:0];
  end

endmodule

@@ hdl/text_console_writer_core.sv @@
// text_console_writer_core: text console engine, sequencer around a cell RAM.
// Uses tcw_pkg, tcw_ram (screen cells) and tcw_addr_unit (shared address unit).
//
//  channel   signals                          direction  handshake
//  command   start, busy, command             in         taken when start & !busy
//  result    done, result                     out        valid for the single cycle done is high
//  config    cfg_we, cfg_index, cfg_data      in         written when cfg_we is high
//
// After reset a clearing pass writes every cell, with busy high.
// A put with no scroll, set, draw, a rejected read, a backspace at the origin and
// unused codes go from EXEC to POS, which registers the result and done; a backspace
// that moves the cursor passes BLANK for the blank write, and an accepted read passes
// RDWAIT for the registered RAM read. Line feed or wrap on the last row, and clear,
// sweep the RAM once through the shared address unit. done is a one-cycle strobe; the
// receiver cannot stall it, and a new command may be taken in the done cycle.
module text_console_writer_core #(
  parameter int ROWS = tcw_pkg::DEF_ROWS,
  parameter int COLS = tcw_pkg::DEF_COLS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  tcw_pkg::cmd_t                    command,
  output logic                             done,
  output tcw_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NCELLS = ROWS * COLS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = $clog2(NCELLS);
  localparam int PW = $clog2(NCELLS + 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_BLANK  = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;
  localparam logic [2:0] ST_SWEEP  = 3'd5;
  localparam logic [2:0] ST_POS    = 3'd6;

  logic [2:0] state;

  tcw_pkg::cmd_t item;
  logic [7:0]    text_color;
  logic          cursor_visible;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic          status;
  logic [7:0]    rd_char;

  // sweep (init, scroll, clear)
  logic [AW-1:0] sweep_idx;
  logic          sweep_run;
  logic          sweep_clear;
  logic          pend_valid;
  logic          pend_blank;
  logic [AW-1:0] pend_addr;

  // shared address unit
  logic [RW-1:0] unit_a;
  logic [AW-1:0] unit_b;
  logic [AW-1:0] unit_sum;

  // cell RAM
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;

  logic on_grid;
  logic printable;
  logic at_last_row;
  logic at_last_col;
  logic sweep_shift;
  logic [PW-1:0] pos;

  always_comb begin
    on_grid     = (item.row < 8'(ROWS)) && (item.col < 8'(COLS));
    printable   = (item.char_code != tcw_pkg::CHAR_CR) && (item.char_code != tcw_pkg::CHAR_LF)
                  && (item.char_code != tcw_pkg::CHAR_BS);
    at_last_row = (cur_row == RW'(ROWS - 1));
    at_last_col = (cur_col == CW'(COLS - 1));
    sweep_shift = !sweep_clear && (sweep_idx < AW'(NCELLS - COLS));
  end

  // operand select for the address unit
  always_comb begin
    unit_a = cur_row;
    unit_b = AW'(cur_col);
    case (state)
      ST_EXEC: begin
        if (item.cmd == tcw_pkg::CMD_DRAW || item.cmd == tcw_pkg::CMD_READ) begin
          unit_a = item.row[RW-1:0];
          unit_b = AW'(item.col[CW-1:0]);
        end
      end
      ST_SWEEP: begin
        unit_a = sweep_shift ? RW'(1) : RW'(0);
        unit_b = sweep_idx;
      end
      default: begin
        unit_a = cur_row;
        unit_b = AW'(cur_col);
      end
    endcase
  end

  tcw_addr_unit #(
    .COLS  (COLS),
    .ROW_W (RW),
    .ADDR_W(AW)
  ) u_addr (
    .a  (unit_a),
    .b  (unit_b),
    .sum(unit_sum)
  );

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = unit_sum;
    ram_wdata = {text_color, item.char_code};
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = tcw_pkg::RESET_CELL;
      end
      ST_EXEC: begin
        if (item.cmd == tcw_pkg::CMD_PUT) begin
          ram_we = printable;
        end else if (item.cmd == tcw_pkg::CMD_DRAW) begin
          ram_we    = on_grid;
          ram_wdata = {item.draw_color, item.char_code};
        end
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = {text_color, tcw_pkg::SPACE_CHAR};
      end
      ST_SWEEP: begin
        ram_we    = pend_valid;
        ram_waddr = pend_addr;
        ram_wdata = pend_blank ? {ram_rdata[15:8], tcw_pkg::SPACE_CHAR} : ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(NCELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(unit_sum),
    .rdata(ram_rdata)
  );

  assign busy = (state != ST_IDLE);
  assign pos  = cursor_visible ? PW'(unit_sum) : PW'(NCELLS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color     <= tcw_pkg::RESET_COLOR;
      cursor_visible <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == tcw_pkg::CFG_TEXT_COLOR) begin
        text_color <= cfg_data;
      end else if (cfg_index == tcw_pkg::CFG_CURSOR_VISIBLE) begin
        cursor_visible <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep_idx  <= '0;
      sweep_run  <= 1'b0;
      sweep_clear <= 1'b0;
      pend_valid <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_INIT: begin
          if (sweep_idx == AW'(NCELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            sweep_idx <= sweep_idx + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            item  <= command;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          status  <= 1'b0;
          rd_char <= '0;
          state   <= ST_POS;
          case (item.cmd)
            tcw_pkg::CMD_PUT: begin
              if (item.char_code == tcw_pkg::CHAR_CR) begin
                cur_col <= '0;
              end else if (item.char_code == tcw_pkg::CHAR_BS) begin
                if (cur_col != '0) begin
                  cur_col <= cur_col - CW'(1);
                  state   <= ST_BLANK;
                end else if (cur_row != '0) begin
                  cur_row <= cur_row - RW'(1);
                  cur_col <= CW'(COLS - 1);
                  state   <= ST_BLANK;
                end
              end else if (printable && !at_last_col) begin
                cur_col <= cur_col + CW'(1);
              end else begin
                // line feed, or wrap after a printable byte in the last column
                cur_col <= '0;
                if (at_last_row) begin
                  sweep_idx   <= '0;
                  sweep_run   <= 1'b1;
                  sweep_clear <= 1'b0;
                  pend_valid  <= 1'b0;
                  state       <= ST_SWEEP;
                end else begin
                  cur_row <= cur_row + RW'(1);
                end
              end
            end
            tcw_pkg::CMD_SET: begin
              if (on_grid) begin
                cur_row <= item.row[RW-1:0];
                cur_col <= item.col[CW-1:0];
              end else begin
                status <= 1'b1;
              end
            end
            tcw_pkg::CMD_DRAW: begin
              status <= !on_grid;
            end
            tcw_pkg::CMD_READ: begin
              if (on_grid) begin
                state <= ST_RDWAIT;
              end else begin
                status <= 1'b1;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_row     <= '0;
              cur_col     <= '0;
              sweep_idx   <= '0;
              sweep_run   <= 1'b1;
              sweep_clear <= 1'b1;
              pend_valid  <= 1'b0;
              state       <= ST_SWEEP;
            end
            default: begin
              state <= ST_POS;
            end
          endcase
        end
        ST_BLANK: begin
          state <= ST_POS;
        end
        ST_RDWAIT: begin
          rd_char <= ram_rdata[7:0];
          state   <= ST_POS;
        end
        ST_SWEEP: begin
          // issue one read per cycle; the write of each cell follows in the cycle after its read
          if (sweep_run) begin
            pend_valid <= 1'b1;
            pend_addr  <= sweep_idx;
            pend_blank <= !sweep_shift;
            if (sweep_idx == AW'(NCELLS - 1)) begin
              sweep_run <= 1'b0;
            end else begin
              sweep_idx <= sweep_idx + AW'(1);
            end
          end else begin
            pend_valid <= 1'b0;
            state      <= ST_POS;
          end
        end
        ST_POS: begin
          result.status     <= status;
          result.read_char  <= rd_char;
          result.pos_row    <= 5'(cur_row);
          result.pos_col    <= 7'(cur_col);
          result.cursor_pos <= 11'(pos);
          done              <= 1'b1;
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/text_console_writer_core_tb.sv @@
// text_console_writer_core_tb: self-checking bench for the text console engine.
// Depends on tcw_pkg and text_console_writer_core; predicts every result from a
// shadow copy of the screen, cursor and registers and checks it field by field.
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int ROWS = DEF_ROWS;
  localparam int COLS = DEF_COLS;
  localparam int NCELLS = ROWS * COLS;
  localparam int ITEMS_PER_PHASE = 267;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t command = '0;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  text_console_writer_core #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow of the console state
  logic [15:0] screen_shadow [NCELLS];
  int shadow_row;
  int shadow_col;
  logic [7:0] shadow_attr;
  logic shadow_vis;

  cmd_t pending[$];
  result_t due_results[$];
  int errors = 0;
  int n_queued = 0;
  int n_taken = 0;
  int gap_pct = 19;
  bit in_hand = 1'b0;
  bit settle = 1'b0;

  function automatic void set_cell(int r, int c, logic [7:0] ch, logic [7:0] attr);
    screen_shadow[r * COLS + c] = {attr, ch};
  endfunction

  function automatic void blank_rows(int first_cell);
    for (int i = first_cell; i < NCELLS; i++) screen_shadow[i][7:0] = SPACE_CHAR;
  endfunction

  function automatic void next_line();
    shadow_col = 0;
    if (shadow_row >= ROWS - 1) begin
      for (int i = 0; i < NCELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      blank_rows(NCELLS - COLS);
    end else begin
      shadow_row++;
    end
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (ch == CHAR_CR) begin
      shadow_col = 0;
    end else if (ch == CHAR_LF) begin
      next_line();
    end else if (ch == CHAR_BS) begin
      if (shadow_col > 0) begin
        shadow_col--;
        set_cell(shadow_row, shadow_col, SPACE_CHAR, shadow_attr);
      end else if (shadow_row > 0) begin
        shadow_row--;
        shadow_col = COLS - 1;
        set_cell(shadow_row, shadow_col, SPACE_CHAR, shadow_attr);
      end
    end else begin
      set_cell(shadow_row, shadow_col, ch, shadow_attr);
      if (shadow_col < COLS - 1) shadow_col++;
      else next_line();
    end
  endfunction

  function automatic result_t console_step(cmd_t it);
    result_t res;
    logic on_screen;
    res = '0;
    on_screen = (int'(it.row) < ROWS) && (int'(it.col) < COLS);
    case (it.cmd)
      CMD_PUT: put_char(it.char_code);
      CMD_SET: begin
        if (on_screen) begin
          shadow_row = int'(it.row);
          shadow_col = int'(it.col);
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_DRAW: begin
        if (on_screen) set_cell(int'(it.row), int'(it.col), it.char_code, it.draw_color);
        else res.status = 1'b1;
      end
      CMD_READ: begin
        if (on_screen) res.read_char = screen_shadow[int'(it.row) * COLS + int'(it.col)][7:0];
        else res.status = 1'b1;
      end
      CMD_CLEAR: begin
        blank_rows(0);
        shadow_row = 0;
        shadow_col = 0;
      end
      default: ;
    endcase
    res.pos_row = 5'(shadow_row);
    res.pos_col = 7'(shadow_col);
    res.cursor_pos = shadow_vis ? 11'(shadow_row * COLS + shadow_col) : 11'(NCELLS);
    return res;
  endfunction

  // Sender: present items from the pending queue, predict on acceptance
  always @(posedge clk) begin : feed
    logic want_next;
    if (!rst) begin
      want_next = !start;
      if (start && !busy) begin
        due_results.push_back(console_step(command));
        in_hand = 1'b0;
        want_next = 1'b1;
        n_taken++;
        if ($urandom_range(49) == 0 || n_taken == 100) settle = 1'b1;
      end
      if (want_next) begin
        if (settle && due_results.size() == 0) settle = 1'b0;
        if (pending.size() != 0 && !settle && $urandom_range(99) >= gap_pct) begin
          command <= pending.pop_front();
          start <= 1'b1;
          in_hand = 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        $display("%0t: result %p with no item outstanding", $time, result);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, result.status);
        check_field("read_char", want.read_char, result.read_char);
        check_field("pos_row", want.pos_row, result.pos_row);
        check_field("pos_col", want.pos_col, result.pos_col);
        check_field("cursor_pos", want.cursor_pos, result.cursor_pos);
      end
    end
  end

  task automatic queue_item(logic [2:0] op, logic [7:0] ch, logic [7:0] r, logic [7:0] c,
                            logic [7:0] attr);
    cmd_t it;
    it.cmd = op;
    it.char_code = ch;
    it.row = r;
    it.col = c;
    it.draw_color = attr;
    pending.push_back(it);
    if (op <= CMD_CLEAR) n_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEXT_COLOR: shadow_attr = data;
      CFG_CURSOR_VISIBLE: shadow_vis = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending.size() != 0 || in_hand || due_results.size() != 0);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  // Favor the last row and the line end, where wraps and scrolls happen
  function automatic int pick_row();
    int k;
    k = $urandom_range(99);
    if (k < 40) return ROWS - 1;
    if (k < 55) return 0;
    return $urandom_range(ROWS - 1);
  endfunction

  function automatic int pick_col();
    int k;
    k = $urandom_range(99);
    if (k < 35) return COLS - 1 - $urandom_range(3);
    if (k < 50) return 0;
    return $urandom_range(COLS - 1);
  endfunction

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(99);
    if (k < 12) return CHAR_CR;
    if (k < 24) return CHAR_LF;
    if (k < 36) return CHAR_BS;
    return any_byte();
  endfunction

  function automatic logic [7:0] off_screen(int limit);
    return $urandom_range(1) ? 8'(limit) : 8'($urandom_range(255, limit));
  endfunction

  task automatic add_random_group();
    int kind;
    int r;
    int c;
    kind = $urandom_range(99);
    r = pick_row();
    c = pick_col();
    if (kind < 45) begin
      // text run, then read back around where it started
      queue_item(CMD_SET, any_byte(), 8'(r), 8'(c), any_byte());
      repeat ($urandom_range(1, 8)) queue_item(CMD_PUT, pick_char(), any_byte(), any_byte(),
                                                 any_byte());
      repeat ($urandom_range(1, 3))
        queue_item(CMD_READ, any_byte(), 8'(r > 0 ? r - $urandom_range(1) : r),
                   8'((c + $urandom_range(7)) % COLS), any_byte());
    end else if (kind < 60) begin
      r = $urandom_range(ROWS - 1);
      c = $urandom_range(COLS - 1);
      queue_item(CMD_DRAW, any_byte(), 8'(r), 8'(c), any_byte());
      queue_item(CMD_READ, any_byte(), 8'(r), 8'(c), any_byte());
    end else if (kind < 70) begin
      queue_item(CMD_SET, any_byte(), 8'(ROWS - 1 - $urandom_range(1)), 8'(c), any_byte());
      repeat ($urandom_range(2, 6)) queue_item(CMD_PUT, pick_char(), any_byte(), any_byte(),
                                                 any_byte());
      queue_item(CMD_READ, any_byte(), 8'(ROWS - 2), 8'(c), any_byte());
    end else if (kind < 76) begin
      r = $urandom_range(ROWS - 1);
      queue_item(CMD_SET, any_byte(), 8'(r), 8'($urandom_range(2)), any_byte());
      repeat ($urandom_range(1, 4)) queue_item(CMD_PUT, CHAR_BS, any_byte(), any_byte(),
                                                 any_byte());
      queue_item(CMD_READ, any_byte(), 8'(r > 0 ? r - 1 : 0), 8'(COLS - 1), any_byte());
    end else if (kind < 78) begin
      queue_item(CMD_CLEAR, any_byte(), any_byte(), any_byte(), any_byte());
    end else if (kind < 86) begin
      // set, draw or read, with row and column each off the screen at random
      queue_item(3'($urandom_range(CMD_SET, CMD_READ)), any_byte(),
                 $urandom_range(1) ? off_screen(ROWS) : 8'(r),
                 $urandom_range(1) ? off_screen(COLS) : 8'(c), any_byte());
    end else if (kind < 93) begin
      queue_item(3'($urandom_range(CMD_PUT, CMD_READ)), any_byte(), 8'(r), 8'(c), any_byte());
    end else begin
      queue_item(3'($urandom_range(7)), any_byte(), any_byte(), any_byte(), any_byte());
    end
  endtask

  initial begin : stimulus
    int base;
    for (int i = 0; i < NCELLS; i++) screen_shadow[i] = RESET_CELL;
    shadow_row = 0;
    shadow_col = 0;
    shadow_attr = RESET_COLOR;
    shadow_vis = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_reg(CFG_TEXT_COLOR, 8'hA5);
    write_reg(CFG_CURSOR_VISIBLE, 8'h01);
    for (int k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++) write_reg(CFG_IDX_W'(k), 8'hFF);

    queue_item(CMD_READ, 8'h00, 8'd0, 8'd0, 8'h00);
    queue_item(CMD_PUT, 8'h41, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_PUT, CHAR_BS, 8'hFF, 8'hFF, 8'hFF);
    queue_item(CMD_PUT, CHAR_BS, 8'h00, 8'h00, 8'h00);  // at origin: no change
    queue_item(CMD_PUT, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_PUT, 8'hFF, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_PUT, CHAR_CR, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_PUT, CHAR_LF, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_PUT, CHAR_BS, 8'h00, 8'h00, 8'h00);  // line start: back to previous row
    queue_item(CMD_SET, 8'h00, 8'(ROWS - 1), 8'(COLS - 1), 8'h00);
    queue_item(CMD_PUT, 8'h5A, 8'h00, 8'h00, 8'h00);    // wrap on last row scrolls
    queue_item(CMD_READ, 8'h00, 8'(ROWS - 2), 8'(COLS - 1), 8'h00);
    queue_item(CMD_PUT, CHAR_LF, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_SET, 8'h00, 8'(ROWS), 8'h00, 8'h00);
    queue_item(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_item(CMD_DRAW, 8'h51, 8'h00, 8'h00, 8'hFF);
    queue_item(CMD_DRAW, 8'hFF, 8'(ROWS - 1), 8'(COLS - 1), 8'h00);
    queue_item(CMD_DRAW, 8'h51, 8'(ROWS), 8'h00, 8'h00);
    queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_READ, 8'h00, 8'(ROWS - 1), 8'(COLS - 1), 8'h00);
    queue_item(CMD_READ, 8'h00, 8'h00, 8'(COLS), 8'h00);
    for (int k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++)
      queue_item(3'(k), any_byte(), any_byte(), any_byte(), any_byte());
    queue_item(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          gap_pct = 19;
          write_reg(CFG_TEXT_COLOR, 8'h00);
          write_reg(CFG_CURSOR_VISIBLE, 8'h00);
        end
        1: begin
          gap_pct = 78;
          write_reg(CFG_TEXT_COLOR, 8'hFF);
          write_reg(CFG_CURSOR_VISIBLE, 8'h01);
        end
        default: begin
          gap_pct = 0;
          write_reg(CFG_TEXT_COLOR, any_byte());
          write_reg(CFG_CURSOR_VISIBLE, 8'($urandom_range(1)));
        end
      endcase
      base = n_queued;
      while (n_queued - base < ITEMS_PER_PHASE) add_random_group();
      wait_idle();
    end

    // allow a late or stray result to show up
    repeat (NCELLS + 64) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("text_console_writer_core_tb: clean");
    end else begin
      $display("text_console_writer_core_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("text_console_writer_core_tb: errors");
    $finish;
  end

endmodule
